// File: rtl/core/bmpc_pkg.sv
`default_nettype none

package bmpc_pkg;

    localparam int unsigned MAX_PACKET_BYTES_DEF = 65535;
    localparam int unsigned COUNT_W              = 16;
    localparam int unsigned HEADER_BYTES         = 12;
    localparam int unsigned MIN_PACKET_BYTES     = 14;
    localparam int unsigned SBE_HEADER_BYTES     = 8;
    localparam logic [15:0] DEFAULT_MAX_LEN      = 16'd1024;
    localparam int unsigned QUEUE_DEPTH          = 4;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_BODY,
        PH_DRAIN
    } phase_t;

    typedef enum logic [2:0] {
        ST_VALID,
        ST_PACKET_SHORT,
        ST_PARTIAL_LENGTH,
        ST_ZERO_LENGTH,
        ST_TOO_LARGE,
        ST_INCOMPLETE,
        ST_BELOW_HEADER
    } status_t;

    typedef enum logic {
        KIND_MESSAGE,
        KIND_STATUS
    } kind_t;

    typedef struct packed {
        kind_t       record_kind;
        logic        last_of_run;
        status_t     status_code;
        logic [31:0] seq_num;
        logic [63:0] send_time;
        logic [15:0] message_total;
        logic [15:0] length_field_offset;
        logic [15:0] message_length;
        logic [15:0] blk_len;
        logic [15:0] tmpl_num;
        logic [15:0] schema_num;
        logic [15:0] schema_version;
    } record_t;

    // Up to two records per input byte: a message record and a packet status.
    typedef struct packed {
        logic [1:0] count;
        record_t    first;
        record_t    second;
    } push_t;

endpackage

`default_nettype wire

// File: rtl/core/bmpc_in_if.sv
`default_nettype none

interface bmpc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_packet;

    modport source (output valid, output data_byte, output end_of_packet, input ready);
    modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bmpc_out_if.sv
`default_nettype none

interface bmpc_out_if;
    logic        valid;
    logic        ready;
    logic        record_kind;
    logic        last_of_run;
    logic [2:0]  status_code;
    logic [31:0] seq_num;
    logic [63:0] send_time;
    logic [15:0] message_total;
    logic [15:0] length_field_offset;
    logic [15:0] message_length;
    logic [15:0] blk_len;
    logic [15:0] tmpl_num;
    logic [15:0] schema_num;
    logic [15:0] schema_version;

    modport source (
        output valid, input ready,
        output record_kind, output last_of_run, output status_code,
        output seq_num, output send_time, output message_total,
        output length_field_offset, output message_length, output blk_len,
        output tmpl_num, output schema_num, output schema_version
    );
    modport sink (
        input valid, output ready,
        input record_kind, input last_of_run, input status_code,
        input seq_num, input send_time, input message_total,
        input length_field_offset, input message_length, input blk_len,
        input tmpl_num, input schema_num, input schema_version
    );
endinterface

`default_nettype wire

// File: rtl/core/bmpc_parser.sv
`default_nettype none

module bmpc_parser #(
    parameter int unsigned MAX_PACKET_BYTES = bmpc_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire logic [15:0]   cfg_wr_data,
    input  wire logic          accept,
    input  wire logic [7:0]    data_byte,
    input  wire logic          end_of_packet,
    output bmpc_pkg::push_t    push
);
    import bmpc_pkg::*;

    localparam logic [COUNT_W-1:0] SAT_COUNT = COUNT_W'(MAX_PACKET_BYTES);
    localparam logic [COUNT_W-1:0] HDR_LAST  = COUNT_W'(HEADER_BYTES - 1);
    localparam logic [COUNT_W-1:0] MIN_PKT   = COUNT_W'(MIN_PACKET_BYTES);
    localparam logic [15:0]        SBE_HDR   = 16'(SBE_HEADER_BYTES);

    logic [15:0]        max_len_reg;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    phase_t             phase_reg, phase_next;
    logic [31:0]        seq_reg, seq_next;
    logic [63:0]        time_reg, time_next;
    logic [7:0]         len_lo_reg, len_lo_next;
    logic [15:0]        cur_len_reg, cur_len_next;
    logic [15:0]        body_rem_reg, body_rem_next;
    logic [3:0][15:0]   hw_reg, hw_next;
    logic [15:0]        field_off_reg, field_off_next;
    logic [15:0]        count_reg, count_next;
    status_t            err_reg, err_next;

    logic [15:0] len_word;
    logic [15:0] rem_dec;
    logic [15:0] body_idx;
    logic [2:0]  time_idx;
    logic        body_end;
    logic        msg_done;
    status_t     pkt_status;
    record_t     msg_rec;
    record_t     stat_rec;

    assign len_word = {data_byte, len_lo_reg};
    assign rem_dec  = body_rem_reg - 16'd1;
    assign body_idx = cur_len_reg - body_rem_reg;
    assign time_idx = byte_count_reg[2:0] - 3'd4;
    assign body_end = (phase_reg == PH_BODY) && (rem_dec == 16'd0);
    assign msg_done = body_end && (cur_len_reg >= SBE_HDR);

    // Phase and error latch
    always_comb
    begin
        phase_next = phase_reg;
        err_next   = err_reg;
        case (phase_reg)
            PH_HEADER:
            begin
                if (byte_count_reg >= HDR_LAST)
                    phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
                phase_next = PH_LEN_HI;
            PH_LEN_HI:
            begin
                if (len_word == 16'd0)
                begin
                    err_next   = ST_ZERO_LENGTH;
                    phase_next = PH_DRAIN;
                end
                else if (len_word > max_len_reg)
                begin
                    err_next   = ST_TOO_LARGE;
                    phase_next = PH_DRAIN;
                end
                else
                    phase_next = PH_BODY;
            end
            PH_BODY:
            begin
                if (body_end)
                begin
                    if (msg_done)
                        phase_next = PH_LEN_LO;
                    else
                    begin
                        err_next   = ST_BELOW_HEADER;
                        phase_next = PH_DRAIN;
                    end
                end
            end
            default:
                phase_next = PH_DRAIN;
        endcase
    end

    // Datapath
    always_comb
    begin
        byte_count_next = byte_count_reg;
        seq_next        = seq_reg;
        time_next       = time_reg;
        len_lo_next     = len_lo_reg;
        cur_len_next    = cur_len_reg;
        body_rem_next   = body_rem_reg;
        hw_next         = hw_reg;
        field_off_next  = field_off_reg;
        count_next      = count_reg;

        if (byte_count_reg < SAT_COUNT)
            byte_count_next = byte_count_reg + COUNT_W'(1);

        case (phase_reg)
            PH_HEADER:
            begin
                if (byte_count_reg < COUNT_W'(4))
                    seq_next[8*byte_count_reg[1:0] +: 8] = data_byte;
                else if (byte_count_reg < COUNT_W'(HEADER_BYTES))
                    time_next[8*time_idx +: 8] = data_byte;
            end
            PH_LEN_LO:
            begin
                field_off_next = 16'(byte_count_reg);
                len_lo_next    = data_byte;
            end
            PH_LEN_HI:
            begin
                cur_len_next = len_word;
                if ((len_word != 16'd0) && (len_word <= max_len_reg))
                begin
                    body_rem_next = len_word;
                    hw_next       = '0;
                end
            end
            PH_BODY:
            begin
                if (body_idx < SBE_HDR)
                    hw_next[body_idx[2:1]][8*body_idx[0] +: 8] = data_byte;
                body_rem_next = rem_dec;
                if (msg_done)
                    count_next = count_reg + 16'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (byte_count_next < MIN_PKT)
            pkt_status = ST_PACKET_SHORT;
        else if (err_next != ST_VALID)
            pkt_status = err_next;
        else if (phase_next == PH_LEN_HI)
            pkt_status = ST_PARTIAL_LENGTH;
        else if (phase_next == PH_BODY)
            pkt_status = ST_INCOMPLETE;
        else
            pkt_status = ST_VALID;
    end

    always_comb
    begin
        msg_rec                     = '0;
        msg_rec.record_kind         = KIND_MESSAGE;
        msg_rec.last_of_run         = !end_of_packet;
        msg_rec.status_code         = ST_VALID;
        msg_rec.seq_num             = seq_next;
        msg_rec.send_time           = time_next;
        msg_rec.message_total       = count_next;
        msg_rec.length_field_offset = field_off_next;
        msg_rec.message_length      = cur_len_next;
        msg_rec.blk_len             = hw_next[0];
        msg_rec.tmpl_num            = hw_next[1];
        msg_rec.schema_num          = hw_next[2];
        msg_rec.schema_version      = hw_next[3];

        stat_rec                 = '0;
        stat_rec.record_kind     = KIND_STATUS;
        stat_rec.last_of_run     = 1'b1;
        stat_rec.status_code     = pkt_status;
        stat_rec.message_total   = count_next;
        if (pkt_status != ST_PACKET_SHORT)
        begin
            stat_rec.seq_num   = seq_next;
            stat_rec.send_time = time_next;
        end

        push.count  = accept ? (2'(msg_done) + 2'(end_of_packet)) : 2'd0;
        push.first  = msg_done ? msg_rec : stat_rec;
        push.second = stat_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= DEFAULT_MAX_LEN;
        else if (cfg_wr_en)
            max_len_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            phase_reg      <= PH_HEADER;
            seq_reg        <= '0;
            time_reg       <= '0;
            len_lo_reg     <= '0;
            cur_len_reg    <= '0;
            body_rem_reg   <= '0;
            hw_reg         <= '0;
            field_off_reg  <= '0;
            count_reg      <= '0;
            err_reg        <= ST_VALID;
        end
        else if (accept)
        begin
            if (end_of_packet)
            begin
                byte_count_reg <= '0;
                phase_reg      <= PH_HEADER;
                seq_reg        <= '0;
                time_reg       <= '0;
                len_lo_reg     <= '0;
                cur_len_reg    <= '0;
                body_rem_reg   <= '0;
                hw_reg         <= '0;
                field_off_reg  <= '0;
                count_reg      <= '0;
                err_reg        <= ST_VALID;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                phase_reg      <= phase_next;
                seq_reg        <= seq_next;
                time_reg       <= time_next;
                len_lo_reg     <= len_lo_next;
                cur_len_reg    <= cur_len_next;
                body_rem_reg   <= body_rem_next;
                hw_reg         <= hw_next;
                field_off_reg  <= field_off_next;
                count_reg      <= count_next;
                err_reg        <= err_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bmpc_queue.sv
`default_nettype none

module bmpc_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bmpc_pkg::push_t push,
    input  wire logic          pop,
    output bmpc_pkg::record_t  head,
    output logic               not_empty,
    output logic               has_room
);
    import bmpc_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;

    record_t [QUEUE_DEPTH-1:0] entry_reg;
    logic [PTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [PTR_W-1:0]          wr_ptr_inc;

    assign wr_ptr_inc = wr_ptr_reg + PTR_W'(1);
    assign head       = entry_reg[rd_ptr_reg];
    assign not_empty  = (cnt_reg != '0);
    // Room for the two records one byte can raise
    assign has_room   = (cnt_reg <= CNT_W'(QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_inc] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/binary_market_packet_checker.sv
// Packet framing checker for a byte stream of binary market-data packets. One byte
// is taken per cycle; the final byte of a packet carries end_of_packet. The 12-byte
// header gives sequence number and sending time, then each framed message (2-byte
// length, body) yields a message record when a body of 8 bytes or more completes,
// and the final byte yields a packet status record, so one byte may raise two
// records. The first error in a packet is held and the rest drained. Throughput is
// one byte per clock: records go to a four-entry output queue, and the input stalls
// only while that queue holds more than two records. max_message_length resets to
// 1024 and should be written between packets.
`default_nettype none

module binary_market_packet_checker #(
    parameter int unsigned MAX_PACKET_BYTES = bmpc_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    bmpc_in_if.sink          in_chan,
    bmpc_out_if.source       out_chan
);
    import bmpc_pkg::*;

    push_t   push;
    record_t head;
    logic    accept;
    logic    not_empty;
    logic    has_room;

    assign in_chan.ready = has_room;
    assign accept        = in_chan.valid && has_room;

    bmpc_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .accept        (accept),
        .data_byte     (in_chan.data_byte),
        .end_of_packet (in_chan.end_of_packet),
        .push          (push)
    );

    bmpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (not_empty && out_chan.ready),
        .head      (head),
        .not_empty (not_empty),
        .has_room  (has_room)
    );

    assign out_chan.valid               = not_empty;
    assign out_chan.record_kind         = head.record_kind;
    assign out_chan.last_of_run         = head.last_of_run;
    assign out_chan.status_code         = head.status_code;
    assign out_chan.seq_num             = head.seq_num;
    assign out_chan.send_time           = head.send_time;
    assign out_chan.message_total       = head.message_total;
    assign out_chan.length_field_offset = head.length_field_offset;
    assign out_chan.message_length      = head.message_length;
    assign out_chan.blk_len             = head.blk_len;
    assign out_chan.tmpl_num            = head.tmpl_num;
    assign out_chan.schema_num          = head.schema_num;
    assign out_chan.schema_version      = head.schema_version;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none

module tb_top;
    import bmpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_BYTES   = 720;
    localparam int MAX_RANDOM_PKT = 200;
    localparam int UNTYPED        = -1;
    localparam int NUM_ROWS       = 22;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    typedef struct {
        int    max_len;    // 0: register left alone
        fill_t fill;
        int    n_msgs;
        int    msg_len;
        int    last_len;   // -1: no trailing message
        int    total;      // 0: packet ends where the framing ends
        int    status;
    } pkt_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    bmpc_in_if  in_chan ();
    bmpc_out_if out_chan ();

    binary_market_packet_checker u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_chan     (in_chan),
        .out_chan    (out_chan)
    );

    // packet decoder state
    logic [15:0] max_len_q;
    logic [15:0] seen_q;
    phase_t      phase_q;
    logic [31:0] seq_q;
    logic [63:0] send_time_q;
    logic [7:0]  len_lo_q;
    logic [15:0] msg_len_q;
    logic [15:0] body_left_q;
    logic [15:0] words_q [4];
    logic [15:0] field_off_q;
    logic [15:0] msg_count_q;
    status_t     err_q;

    record_t     pending_records [$];
    logic [7:0]  pkt_q [$];
    int          record_errors;
    int          bytes_sent;
    int          send_idle_pct;
    int          recv_stall_pct;

    pkt_row_t directed_rows [NUM_ROWS] = '{
        '{0,     FILL_RANDOM, 0,  0,    -1,    1,   ST_PACKET_SHORT},
        '{0,     FILL_ONES,   0,  0,    -1,    12,  ST_PACKET_SHORT},
        '{0,     FILL_ONES,   0,  0,    -1,    13,  ST_PACKET_SHORT},
        '{0,     FILL_ZERO,   1,  8,    -1,    0,   ST_VALID},
        '{0,     FILL_ONES,   1,  8,    -1,    0,   ST_VALID},
        '{0,     FILL_RANDOM, 0,  0,    0,     0,   ST_ZERO_LENGTH},
        '{0,     FILL_RANDOM, 2,  8,    0,     40,  ST_ZERO_LENGTH},
        '{0,     FILL_RANDOM, 0,  0,    1025,  14,  ST_TOO_LARGE},
        '{0,     FILL_RANDOM, 1,  9,    1025,  50,  ST_TOO_LARGE},
        '{0,     FILL_RANDOM, 0,  0,    1024,  100, ST_INCOMPLETE},
        '{0,     FILL_RANDOM, 0,  0,    8,     14,  ST_INCOMPLETE},
        '{0,     FILL_RANDOM, 0,  0,    1,     0,   ST_BELOW_HEADER},
        '{0,     FILL_RANDOM, 1,  10,   7,     27,  ST_INCOMPLETE},
        '{0,     FILL_RANDOM, 0,  0,    3,     30,  ST_BELOW_HEADER},
        '{0,     FILL_RANDOM, 1,  8,    -1,    23,  ST_PARTIAL_LENGTH},
        '{0,     FILL_RANDOM, 5,  20,   -1,    0,   UNTYPED},
        '{0,     FILL_RANDOM, 3,  13,   1,     0,   UNTYPED},
        '{0,     FILL_RANDOM, 3,  20,   -1,    0,   ST_VALID},
        '{8,     FILL_ONES,   2,  8,    -1,    0,   ST_VALID},
        '{0,     FILL_RANDOM, 1,  8,    9,     0,   ST_TOO_LARGE},
        '{65535, FILL_RANDOM, 0,  0,    65535, 40,  ST_INCOMPLETE},
        '{1024,  FILL_RANDOM, 2,  8,    -1,    0,   UNTYPED}
    };

    function automatic void clear_packet_state();
        seen_q      = '0;
        phase_q     = PH_HEADER;
        seq_q       = '0;
        send_time_q = '0;
        len_lo_q    = '0;
        msg_len_q   = '0;
        body_left_q = '0;
        for (int i = 0; i < 4; i++)
            words_q[i] = '0;
        field_off_q = '0;
        msg_count_q = '0;
        err_q       = ST_VALID;
    endfunction

    function automatic void decode_byte(input logic [7:0] d, input logic eop);
        logic [15:0] pos;
        logic [15:0] len;
        logic [15:0] idx;
        record_t     rec;
        status_t     st;

        pos = seen_q;
        if (seen_q != 16'hFFFF)
            seen_q = seen_q + 16'd1;

        case (phase_q)
            PH_HEADER:
            begin
                if (pos < 4)
                    seq_q = seq_q | (32'(d) << (8 * pos));
                else if (pos < HEADER_BYTES)
                    send_time_q = send_time_q | (64'(d) << (8 * (pos - 4)));
                if (pos + 1 >= HEADER_BYTES)
                    phase_q = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                field_off_q = pos;
                len_lo_q    = d;
                phase_q     = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len       = {d, len_lo_q};
                msg_len_q = len;
                if (len == 16'd0)
                begin
                    err_q   = ST_ZERO_LENGTH;
                    phase_q = PH_DRAIN;
                end
                else if (len > max_len_q)
                begin
                    err_q   = ST_TOO_LARGE;
                    phase_q = PH_DRAIN;
                end
                else
                begin
                    body_left_q = len;
                    for (int i = 0; i < 4; i++)
                        words_q[i] = '0;
                    phase_q = PH_BODY;
                end
            end
            PH_BODY:
            begin
                idx = msg_len_q - body_left_q;
                if (idx < SBE_HEADER_BYTES)
                    words_q[idx[2:1]] = words_q[idx[2:1]] | (16'(d) << (8 * idx[0]));
                body_left_q = body_left_q - 16'd1;
                if (body_left_q == 16'd0)
                begin
                    if (msg_len_q < SBE_HEADER_BYTES)
                    begin
                        err_q   = ST_BELOW_HEADER;
                        phase_q = PH_DRAIN;
                    end
                    else
                    begin
                        msg_count_q             = msg_count_q + 16'd1;
                        rec                     = '0;
                        rec.record_kind         = KIND_MESSAGE;
                        rec.last_of_run         = !eop;
                        rec.status_code         = ST_VALID;
                        rec.seq_num             = seq_q;
                        rec.send_time           = send_time_q;
                        rec.message_total       = msg_count_q;
                        rec.length_field_offset = field_off_q;
                        rec.message_length      = msg_len_q;
                        rec.blk_len             = words_q[0];
                        rec.tmpl_num            = words_q[1];
                        rec.schema_num          = words_q[2];
                        rec.schema_version      = words_q[3];
                        pending_records.insert(pending_records.size(), rec);
                        phase_q = PH_LEN_LO;
                    end
                end
            end
            default:
                phase_q = PH_DRAIN;
        endcase

        if (eop)
        begin
            if (seen_q < MIN_PACKET_BYTES)
                st = ST_PACKET_SHORT;
            else if (err_q != ST_VALID)
                st = err_q;
            else if (phase_q == PH_LEN_HI)
                st = ST_PARTIAL_LENGTH;
            else if (phase_q == PH_BODY)
                st = ST_INCOMPLETE;
            else
                st = ST_VALID;
            rec               = '0;
            rec.record_kind   = KIND_STATUS;
            rec.last_of_run   = 1'b1;
            rec.status_code   = st;
            rec.message_total = msg_count_q;
            if (st != ST_PACKET_SHORT)
            begin
                rec.seq_num   = seq_q;
                rec.send_time = send_time_q;
            end
            pending_records.insert(pending_records.size(), rec);
            clear_packet_state();
        end
    endfunction

    function automatic logic [7:0] fill_byte(input fill_t fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void add_header(input fill_t fill);
        for (int i = 0; i < HEADER_BYTES; i++)
            pkt_q.insert(pkt_q.size(), fill_byte(fill));
    endfunction

    function automatic void add_message(input int len, input fill_t fill);
        logic [15:0] l16;

        l16 = 16'(len);
        pkt_q.insert(pkt_q.size(), l16[7:0]);
        pkt_q.insert(pkt_q.size(), l16[15:8]);
        for (int i = 0; i < len; i++)
            pkt_q.insert(pkt_q.size(), fill_byte(fill));
    endfunction

    function automatic void fit_length(input int total);
        while (pkt_q.size() > total)
            void'(pkt_q.pop_back());
        while (pkt_q.size() < total)
            pkt_q.insert(pkt_q.size(), 8'($urandom_range(255)));
    endfunction

    function automatic int pick_length();
        int r;
        int top;

        r   = $urandom_range(99);
        top = (max_len_q < 40) ? int'(max_len_q) : 40;
        if (r < 5)
            return 0;
        if (r < 12)
            return $urandom_range(7, 1);
        if (r < 17 && max_len_q != 16'hFFFF)
            return int'(max_len_q) + 1;
        return $urandom_range(top, 8);
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic eop);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_chan.valid <= 1'b0;
            @(posedge clk);
        end
        in_chan.valid         <= 1'b1;
        in_chan.data_byte     <= d;
        in_chan.end_of_packet <= eop;
        @(posedge clk);
        while (!in_chan.ready)
            @(posedge clk);
        bytes_sent++;
        decode_byte(d, eop);
    endtask

    task automatic send_packet(input int want_status);
        record_t rec;

        for (int i = 0; i < pkt_q.size(); i++)
            send_byte(pkt_q[i], i == pkt_q.size() - 1);
        if (want_status != UNTYPED)
        begin
            rec             = pending_records.pop_back();
            rec.status_code = status_t'(want_status);
            pending_records.insert(pending_records.size(), rec);
        end
        pkt_q.delete();
    endtask

    task automatic write_max_length(input logic [15:0] value);
        in_chan.valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        max_len_q = value;
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            record_errors++;
            if (record_errors <= 10)
                $display("mismatch %s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        record_t want;

        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && out_chan.valid && out_chan.ready)
        begin
            if (pending_records.size() == 0)
            begin
                record_errors++;
                if (record_errors <= 10)
                    $display("unexpected record: kind %0d status %0d",
                             out_chan.record_kind, out_chan.status_code);
            end
            else
            begin
                want = pending_records.pop_front();
                check_field("record_kind", want.record_kind, out_chan.record_kind);
                check_field("last_of_run", want.last_of_run, out_chan.last_of_run);
                check_field("status_code", want.status_code, out_chan.status_code);
                check_field("seq_num", want.seq_num, out_chan.seq_num);
                check_field("send_time", want.send_time, out_chan.send_time);
                check_field("message_total", want.message_total, out_chan.message_total);
                check_field("length_field_offset", want.length_field_offset,
                            out_chan.length_field_offset);
                check_field("message_length", want.message_length,
                            out_chan.message_length);
                check_field("blk_len", want.blk_len, out_chan.blk_len);
                check_field("tmpl_num", want.tmpl_num, out_chan.tmpl_num);
                check_field("schema_num", want.schema_num, out_chan.schema_num);
                check_field("schema_version", want.schema_version,
                            out_chan.schema_version);
            end
        end
    end

    // gives up once no transaction has moved on either channel for too long
    initial
    begin
        int quiet;

        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int         idle_tab [4];
        int         stall_tab [4];
        logic [15:0] phase_max [4];
        int         phase_start;
        int         n;

        idle_tab  = '{0, 50, 0, 19};
        stall_tab = '{0, 0, 50, 19};
        record_errors  = 0;
        bytes_sent     = 0;
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        clear_packet_state();
        max_len_q = DEFAULT_MAX_LEN;

        rst_n                 <= 1'b0;
        cfg_wr_en             <= 1'b0;
        cfg_wr_data           <= '0;
        in_chan.valid         <= 1'b0;
        in_chan.data_byte     <= '0;
        in_chan.end_of_packet <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].max_len != 0)
                write_max_length(16'(directed_rows[i].max_len));
            add_header(directed_rows[i].fill);
            for (int m = 0; m < directed_rows[i].n_msgs; m++)
                add_message(directed_rows[i].msg_len, directed_rows[i].fill);
            if (directed_rows[i].last_len >= 0)
                add_message(directed_rows[i].last_len, directed_rows[i].fill);
            if (directed_rows[i].total != 0)
                fit_length(directed_rows[i].total);
            send_packet(directed_rows[i].status);
        end

        phase_max = '{16'($urandom_range(64, 8)), 16'd8, 16'hFFFF,
                      16'($urandom_range(2000, 9))};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_max_length(phase_max[ph]);
            send_idle_pct  = idle_tab[ph];
            recv_stall_pct = stall_tab[ph];
            phase_start    = bytes_sent;
            while (bytes_sent - phase_start < RANDOM_BYTES / 4)
            begin
                add_header(FILL_RANDOM);
                n = $urandom_range(4);
                for (int m = 0; m < n; m++)
                    add_message(pick_length(), FILL_RANDOM);
                // an oversized length drains the rest, so its body is cut short
                if (pkt_q.size() > MAX_RANDOM_PKT)
                    fit_length($urandom_range(MAX_RANDOM_PKT, 1));
                if ($urandom_range(99) < 15)
                    fit_length($urandom_range(pkt_q.size() + 3, 1));
                else if ($urandom_range(99) < 10)
                    fit_length(pkt_q.size() + 1);
                send_packet(UNTYPED);
            end
        end

        in_chan.valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (record_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/core/bmpc_pkg.sv
rtl/core/bmpc_in_if.sv
rtl/core/bmpc_out_if.sv
rtl/core/bmpc_parser.sv
rtl/core/bmpc_queue.sv
rtl/core/binary_market_packet_checker.sv
sim/tb_top.sv
